// File: rtl/sliding_window_mean_assert.svh
`ifndef SLIDING_WINDOW_MEAN_ASSERT_SVH
`define SLIDING_WINDOW_MEAN_ASSERT_SVH

// Same-cycle check: consequent must hold whenever the antecedent does.
`define SWM_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle check: consequent must hold in the cycle after the antecedent.
`define SWM_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/swm_pkg.sv
package swm_pkg;

   localparam int MAX_WINDOW = 64;
   localparam int SLOT_W     = $clog2(MAX_WINDOW);
   localparam int SAMPLE_W   = 32;
   localparam int COUNT_W    = 7;
   localparam int SUM_W      = 38;
   localparam int STEP_W     = $clog2(SUM_W);

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic        [COUNT_W-1:0]  count_type;
   typedef logic        [SLOT_W-1:0]   slot_type;
   typedef logic signed [SUM_W-1:0]    sum_type;

endpackage

// File: rtl/swm_if.sv
interface swm_req_if;
   logic                 valid;
   logic                 ready;
   swm_pkg::sample_type  sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface swm_rsp_if;
   logic                 valid;
   logic                 ready;
   swm_pkg::sample_type  mean;
   swm_pkg::count_type   held_count;

   modport source (output valid, output mean, output held_count, input ready);
   modport sink   (input valid, input mean, input held_count, output ready);
endinterface

// File: rtl/swm_ram.sv
module swm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/sliding_window_mean.sv
// Sliding-window mean of signed 32-bit samples.
// req_if carries one sample per word (valid/ready); rsp_if returns one word
// per sample: the truncated mean of the samples held and how many were held.
// csr_we/csr_wdata set the window length (0 reads as 1, above 64 as 64);
// a write empties the window. Write it only while the block is idle.
// The oldest sample is read from the ring RAM at the accepting edge; then
// S_UPDATE updates the sum and writes the new sample, S_DIV runs the
// bit-serial magnitude divide of the 38-bit sum by the held count, and
// S_DONE loads the result register. A new sample is taken only in S_IDLE,
// so one sample is in flight at a time.
// Reset (synchronous, active high) empties the window and sets the length
// to 1; the ring RAM contents are not cleared and need not be.
// A stalled receiver holds the result register; the next sample is still
// accepted and computed, and waits in the divider until the register frees.
module sliding_window_mean (
   input  logic                  clock,
   input  logic                  reset,
   swm_req_if.sink               req_if,
   swm_rsp_if.source             rsp_if,
   input  logic                  csr_we,
   input  swm_pkg::count_type    csr_wdata
);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_UPDATE = 4'b0010,
      S_DIV    = 4'b0100,
      S_DONE   = 4'b1000
   } state_type;

   localparam int EXT_W = swm_pkg::SUM_W - swm_pkg::SAMPLE_W;

   state_type               state_ff, state_in;
   swm_pkg::count_type      len_ff, len_in;
   swm_pkg::count_type      fill_ff, fill_in;
   swm_pkg::slot_type       oldest_ff, oldest_in;
   swm_pkg::slot_type       next_ff, next_in;
   swm_pkg::sum_type        sum_ff, sum_in;
   swm_pkg::sample_type     sample_ff, sample_in;
   logic [swm_pkg::SUM_W-1:0]   dvd_ff, dvd_in;
   logic [swm_pkg::COUNT_W-1:0] rem_ff, rem_in;
   swm_pkg::count_type      div_ff, div_in;
   logic                    neg_ff, neg_in;
   logic [swm_pkg::STEP_W-1:0]  step_ff, step_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   swm_pkg::sample_type     rsp_mean_ff, rsp_mean_in;
   swm_pkg::count_type      rsp_count_ff, rsp_count_in;

   logic                    req_take;
   logic                    full;
   logic                    ram_we;
   logic [swm_pkg::SAMPLE_W-1:0] ram_rd_data;
   swm_pkg::sum_type        sample_ext, evict_ext, sum_new;
   logic [swm_pkg::COUNT_W:0]   shifted;
   logic [swm_pkg::COUNT_W+1:0] diff;
   logic [swm_pkg::SAMPLE_W-1:0] quo;
   logic                    rsp_free;

   function automatic swm_pkg::slot_type advance(swm_pkg::slot_type slot,
                                                 swm_pkg::count_type len);
      swm_pkg::count_type n;
      n = swm_pkg::count_type'(slot) + swm_pkg::count_type'(1);
      return (n >= len) ? '0 : swm_pkg::slot_type'(n);
   endfunction

   assign req_if.ready = (state_ff == S_IDLE);
   assign req_take     = req_if.valid && req_if.ready;
   assign full         = (fill_ff >= len_ff);
   assign ram_we       = (state_ff == S_UPDATE);
   assign rsp_free     = !rsp_valid_ff || rsp_if.ready;

   swm_ram #(
      .WIDTH (swm_pkg::SAMPLE_W),
      .DEPTH (swm_pkg::MAX_WINDOW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (next_ff),
      .wr_data (sample_ff),
      .rd_en   (req_take),
      .rd_addr (oldest_ff),
      .rd_data (ram_rd_data)
   );

   assign sample_ext = {{EXT_W{sample_ff[swm_pkg::SAMPLE_W-1]}}, sample_ff};
   assign evict_ext  = full ? {{EXT_W{ram_rd_data[swm_pkg::SAMPLE_W-1]}}, ram_rd_data}
                            : '0;
   assign sum_new    = sum_ff - evict_ext + sample_ext;

   assign shifted = {rem_ff, dvd_ff[swm_pkg::SUM_W-1]};
   assign diff    = {1'b0, shifted} - {2'b00, div_ff};
   assign quo     = dvd_ff[swm_pkg::SAMPLE_W-1:0];

   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      fill_in      = fill_ff;
      oldest_in    = oldest_ff;
      next_in      = next_ff;
      sum_in       = sum_ff;
      sample_in    = sample_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      div_in       = div_ff;
      neg_in       = neg_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_mean_in  = rsp_mean_ff;
      rsp_count_in = rsp_count_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               sample_in = req_if.sample;
               state_in  = S_UPDATE;
            end
         end
         S_UPDATE: begin
            if (full) begin
               oldest_in = advance(oldest_ff, len_ff);
               fill_in   = len_ff;
            end else begin
               fill_in   = fill_ff + swm_pkg::count_type'(1);
            end
            next_in  = advance(next_ff, len_ff);
            sum_in   = sum_new;
            neg_in   = sum_new[swm_pkg::SUM_W-1];
            dvd_in   = sum_new[swm_pkg::SUM_W-1] ? (~sum_new + 1'b1) : sum_new;
            div_in   = full ? len_ff : (fill_ff + swm_pkg::count_type'(1));
            rem_in   = '0;
            step_in  = swm_pkg::STEP_W'(swm_pkg::SUM_W - 1);
            state_in = S_DIV;
         end
         S_DIV: begin
            if (!diff[swm_pkg::COUNT_W+1]) begin
               rem_in = diff[swm_pkg::COUNT_W-1:0];
               dvd_in = {dvd_ff[swm_pkg::SUM_W-2:0], 1'b1};
            end else begin
               rem_in = shifted[swm_pkg::COUNT_W-1:0];
               dvd_in = {dvd_ff[swm_pkg::SUM_W-2:0], 1'b0};
            end
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_mean_in  = neg_ff ? (~quo + 1'b1) : quo;
               rsp_count_in = div_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // window length write: clamp and empty the window
      if (csr_we) begin
         priority if (csr_wdata == '0) begin
            len_in = swm_pkg::count_type'(1);
         end else if (csr_wdata > swm_pkg::count_type'(swm_pkg::MAX_WINDOW)) begin
            len_in = swm_pkg::count_type'(swm_pkg::MAX_WINDOW);
         end else begin
            len_in = csr_wdata;
         end
         fill_in   = '0;
         oldest_in = '0;
         next_in   = '0;
         sum_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         len_ff       <= swm_pkg::count_type'(1);
         fill_ff      <= '0;
         oldest_ff    <= '0;
         next_ff      <= '0;
         sum_ff       <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         fill_ff      <= fill_in;
         oldest_ff    <= oldest_in;
         next_ff      <= next_in;
         sum_ff       <= sum_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff    <= sample_in;
      dvd_ff       <= dvd_in;
      rem_ff       <= rem_in;
      div_ff       <= div_in;
      neg_ff       <= neg_in;
      rsp_mean_ff  <= rsp_mean_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.mean       = rsp_mean_ff;
   assign rsp_if.held_count = rsp_count_ff;

endmodule

// File: rtl/swm_checker.sv
`include "sliding_window_mean_assert.svh"

module swm_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input swm_pkg::count_type rsp_held_count
);

   `SWM_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "rsp word dropped while stalled")
   `SWM_ASSERT_NOW(a_count_range, rsp_valid, (rsp_held_count != '0) && (rsp_held_count <= swm_pkg::count_type'(swm_pkg::MAX_WINDOW)), "held_count out of range")
   `SWM_ASSERT_NEXT(a_busy, req_valid && req_ready, !req_ready, "second word taken while busy")
   `SWM_ASSERT_NOW(a_no_early_rsp, $rose(rsp_valid), !$past(req_valid && req_ready), "result too soon after accept")

endmodule

bind sliding_window_mean swm_checker u_swm_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_if.valid),
   .req_ready      (req_if.ready),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .rsp_held_count (rsp_if.held_count)
);

// File: dv/tb_sliding_window_mean.sv
module tb_sliding_window_mean;

   localparam int                  CYCLE_LIMIT   = 1_500_000;
   localparam int                  RANDOM_WORDS  = 1950;
   localparam int                  SETTLE_CYCLES = 60;
   localparam int                  REPORT_LIMIT  = 10;
   localparam swm_pkg::sample_type SAMPLE_MAX    = swm_pkg::sample_type'(32'h7fff_ffff);
   localparam swm_pkg::sample_type SAMPLE_MIN    = swm_pkg::sample_type'(32'h8000_0000);

   typedef struct packed {
      swm_pkg::sample_type mean;
      swm_pkg::count_type  held_count;
   } mean_word_type;

   class mean_scoreboard;
      swm_pkg::sample_type ring [swm_pkg::MAX_WINDOW];
      longint        window_sum;
      int            held;
      int            oldest_slot;
      int            write_slot;
      int            window_len;
      mean_word_type expected_words [$];
      int            mismatches;
      int            checked;

      function new();
         window_len = 1;
         mismatches = 0;
         checked    = 0;
         clear_window();
      endfunction

      function void clear_window();
         window_sum  = 0;
         held        = 0;
         oldest_slot = 0;
         write_slot  = 0;
      endfunction

      function int step_slot(int slot);
         return (slot + 1 >= window_len) ? 0 : slot + 1;
      endfunction

      function void set_length(swm_pkg::count_type value);
         int len;
         len = int'(value);
         if (len == 0) len = 1;
         if (len > swm_pkg::MAX_WINDOW) len = swm_pkg::MAX_WINDOW;
         window_len = len;
         clear_window();
      endfunction

      function void note_sample(swm_pkg::sample_type s);
         mean_word_type w;
         longint        quotient;
         // drop the oldest sample once the window is full
         if (held >= window_len) begin
            window_sum -= longint'(ring[oldest_slot]);
            oldest_slot = step_slot(oldest_slot);
            held = window_len - 1;
         end
         ring[write_slot] = s;
         write_slot = step_slot(write_slot);
         window_sum += longint'(s);
         held++;
         quotient = window_sum / longint'(held);
         w.mean = quotient[swm_pkg::SAMPLE_W-1:0];
         w.held_count = swm_pkg::count_type'(held);
         expected_words.push_back(w);
      endfunction

      function void check_result(swm_pkg::sample_type mean, swm_pkg::count_type held_count);
         mean_word_type w;
         checked++;
         if (expected_words.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("unexpected result word: mean %0d held %0d", mean, held_count);
            return;
         end
         w = expected_words.pop_front();
         if (mean !== w.mean || held_count !== w.held_count) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("mismatch: expected mean %0d held %0d, got mean %0d held %0d",
                        w.mean, w.held_count, mean, held_count);
         end
      endfunction

      function int pending();
         return expected_words.size();
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               csr_we;
   swm_pkg::count_type csr_wdata;
   int                 cycles = 0;
   int                 words_sent = 0;
   int                 settings_used = 0;

   mean_scoreboard sb = new();

   swm_req_if req ();
   swm_rsp_if rsp ();

   sliding_window_mean dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req),
      .rsp_if    (rsp),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_we) sb.set_length(csr_wdata);
         if (rsp.valid && rsp.ready) sb.check_result(rsp.mean, rsp.held_count);
         if (req.valid && req.ready) sb.note_sample(req.sample);
      end
   end

   function automatic int gap_cycles();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
   endfunction

   function automatic swm_pkg::sample_type pick_sample(int style);
      int r;
      r = $urandom_range(0, 99);
      if (style == 1) return (r < 85) ? SAMPLE_MAX : swm_pkg::sample_type'($urandom);
      if (style == 2) return (r < 85) ? SAMPLE_MIN : swm_pkg::sample_type'($urandom);
      if (r < 10) return SAMPLE_MAX;
      if (r < 20) return SAMPLE_MIN;
      if (r < 30) return swm_pkg::sample_type'(int'($urandom_range(0, 20)) - 10);
      if (r < 40) return swm_pkg::sample_type'(int'($urandom_range(0, 2)) - 1);
      return swm_pkg::sample_type'($urandom);
   endfunction

   initial begin
      int hold;
      int stall_pct;
      int burst;
      hold = 0;
      stall_pct = 0;
      burst = 0;
      rsp.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (burst == 0) begin
            burst = $urandom_range(50, 400);
            stall_pct = $urandom_range(0, 2) * 20;
         end
         burst--;
         if (hold > 0) begin
            rsp.ready <= 1'b0;
            hold--;
         end else begin
            rsp.ready <= 1'b1;
            if ($urandom_range(0, 99) < stall_pct) hold = gap_cycles();
         end
      end
   end

   task automatic send_sample(swm_pkg::sample_type s, int gap);
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.sample <= s;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      words_sent++;
   endtask

   task automatic pause_sender();
      req.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_length(swm_pkg::count_type value);
      pause_sender();
      repeat (8) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      settings_used++;
   endtask

   initial begin
      swm_pkg::sample_type unit_words [4];
      swm_pkg::sample_type triple_words [10];
      swm_pkg::sample_type pair_words [3];
      int                  length_plan [10];
      int                  random_sent;
      int                  plan_idx;
      int                  count;
      int                  style;
      bit                  gappy;

      unit_words   = '{SAMPLE_MAX, SAMPLE_MIN, swm_pkg::sample_type'(-1),
                       swm_pkg::sample_type'(0)};
      triple_words = '{SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX,
                       SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN,
                       swm_pkg::sample_type'(-7), swm_pkg::sample_type'(2)};
      pair_words   = '{swm_pkg::sample_type'(-3), swm_pkg::sample_type'(0),
                       swm_pkg::sample_type'(3)};
      length_plan  = '{127, 0, 64, 65, 2, 1, 63, 3, 100, 17};

      req.valid <= 1'b0;
      req.sample <= '0;
      csr_we <= 1'b0;
      csr_wdata <= '0;
      reset <= 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset length of one, then full-scale runs through a short window
      foreach (unit_words[i]) send_sample(unit_words[i], 0);
      write_length(swm_pkg::count_type'(3));
      foreach (triple_words[i]) send_sample(triple_words[i], i % 2);
      write_length(swm_pkg::count_type'(2));
      foreach (pair_words[i]) send_sample(pair_words[i], 0);
      pause_sender();
      write_length(swm_pkg::count_type'(0));
      send_sample(swm_pkg::sample_type'(5), 1);

      random_sent = 0;
      plan_idx = 0;
      while (random_sent < RANDOM_WORDS) begin
         write_length(swm_pkg::count_type'((plan_idx < 10) ? length_plan[plan_idx]
                                                           : $urandom_range(0, 127)));
         plan_idx++;
         count = $urandom_range(20, 160);
         if (count > RANDOM_WORDS - random_sent) count = RANDOM_WORDS - random_sent;
         style = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 2);
         gappy = $urandom_range(0, 2) != 0;
         for (int i = 0; i < count; i++) begin
            send_sample(pick_sample(style),
                        (gappy && $urandom_range(0, 3) == 0) ? gap_cycles() : 0);
            random_sent++;
            if ($urandom_range(0, 199) == 0) pause_sender();
         end
      end

      pause_sender();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Checked %0d result words from %0d samples over %0d window settings.",
               sb.checked, words_sent, settings_used);
      $display("Windows from 1 to %0d, full-scale and mixed sample runs, gaps on both sides.",
               swm_pkg::MAX_WINDOW);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
